// ===== design/muscle_activation_rate_defines.svh =====
// Assertion macros shared by the muscle activation rate design.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef MUSCLE_ACTIVATION_RATE_DEFINES_SVH
`define MUSCLE_ACTIVATION_RATE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define MAR_ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// condition never holds
`define MAR_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("forbidden condition seen");

`endif

// ===== design/mar_pkg.sv =====
// Types and constants of the muscle activation rate block.
// No dependencies.
package mar_pkg;

	localparam int EXC_W  = 17;
	localparam int REG_W  = 16;
	localparam int RATE_W = 32;
	localparam int CFG_IDX_W = 3;

	// divider widths: denominator, quotient bits, numerator before scaling
	localparam int DEN_W = 50;
	localparam int QUO_W = 34;
	localparam int NUM_W = 50;

	localparam logic [REG_W-1:0] RST_MIN_ACT = 16'd328;
	localparam logic [REG_W-1:0] RST_MAX_EXC = 16'd32768;
	localparam logic [REG_W-1:0] RST_TAU_ACT = 16'd655;
	localparam logic [REG_W-1:0] RST_TAU_DEA = 16'd2621;
	localparam logic             RST_NORM    = 1'b1;

	// 0.5 in the Q2.16 gain term
	localparam logic [17:0] K_HALF = 18'd32768;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_ACT = 3'd0,
		CFG_MAX_EXC = 3'd1,
		CFG_TAU_ACT = 3'd2,
		CFG_TAU_DEA = 3'd3,
		CFG_NORM    = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic neg;
		logic over;
	} mar_meta_t;

endpackage

// ===== design/mar_if.sv =====
// Valid/ready channel interfaces for input and result words.
// Depends on mar_pkg.
interface mar_in_if import mar_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [EXC_W-1:0] excitation;
	logic signed [EXC_W-1:0] activation;
	modport source (output valid, excitation, activation, input ready);
	modport sink (input valid, excitation, activation, output ready);
endinterface

interface mar_out_if import mar_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [RATE_W-1:0] activation_rate;
	logic                     saturated;
	logic                     excitation_over_max;
	modport source (output valid, activation_rate, saturated, excitation_over_max,
		input ready);
	modport sink (input valid, activation_rate, saturated, excitation_over_max,
		output ready);
endinterface

// ===== design/muscle_activation_rate.sv =====
// An accepted word passes stages 1 to 3, the divider entry stage, its quotient-bit stages and the output register.
// One word per cycle while the output is taken or empty; the 34-stage quotient pipeline sets the depth.
// The whole pipeline holds while a result waits and the output is not taken.
// Reset: asynchronous active-low arst_n clears valid bits and loads register defaults.
// Depends on mar_pkg, mar_if, mar_div and muscle_activation_rate_defines.svh.
`include "muscle_activation_rate_defines.svh"
module muscle_activation_rate import mar_pkg::*; #(
	parameter int RATE_FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data,
	mar_in_if.sink               in_ch,
	mar_out_if.source            out_ch
);

	localparam int YW = NUM_W + 1 + RATE_FRAC_BITS;
	localparam int SH_POS = 18 + RATE_FRAC_BITS;
	localparam int SH_NEG = 1 + RATE_FRAC_BITS;

	// configuration registers
	logic [REG_W-1:0] min_act_q, max_exc_q, tau_act_q, tau_dea_q;
	logic             norm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_act_q <= RST_MIN_ACT;
			max_exc_q <= RST_MAX_EXC;
			tau_act_q <= RST_TAU_ACT;
			tau_dea_q <= RST_TAU_DEA;
			norm_q    <= RST_NORM;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_MIN_ACT: min_act_q <= cfg_data;
				CFG_MAX_EXC: max_exc_q <= cfg_data;
				CFG_TAU_ACT: tau_act_q <= cfg_data;
				CFG_TAU_DEA: tau_dea_q <= cfg_data;
				CFG_NORM:    norm_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic en;
	logic out_v_s5;
	assign en = out_ch.ready || !out_v_s5;
	assign in_ch.ready = en;

	// stage 1: clamp inputs, gain term, a*m
	logic [REG_W-1:0] e_c, a_c, m_c;
	logic             v_s1, over_s1;
	logic [REG_W-1:0] e_s1, a_s1, m_s1;
	logic [17:0]      k_s1;
	logic [31:0]      am_s1;

	always_comb begin
		e_c = in_ch.excitation[EXC_W-1] ? '0 : in_ch.excitation[REG_W-1:0];
		a_c = in_ch.activation[EXC_W-1] ? '0 : in_ch.activation[REG_W-1:0];
		if (e_c < min_act_q) e_c = min_act_q;
		if (a_c < min_act_q) a_c = min_act_q;
		if (norm_q)               m_c = 16'd1;
		else if (max_exc_q == '0) m_c = 16'd1;
		else                      m_c = max_exc_q;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s1    <= e_c;
			a_s1    <= a_c;
			m_s1    <= m_c;
			k_s1    <= K_HALF + 18'(a_c) * 18'd3;
			am_s1   <= a_c * m_c;
			over_s1 <= !norm_q && (e_c >= m_c);
		end
	end

	// stage 2: numerator, sign, tau products
	logic signed [33:0] n_c;
	logic [REG_W-1:0]   tau_c;
	logic               pos_c;
	logic               v_s2, over_s2, pos_s2;
	logic [32:0]        absn_s2;
	logic [33:0]        tk_s2;
	logic [31:0]        tm_s2;
	logic [17:0]        k_s2;
	logic [REG_W-1:0]   m_s2;

	always_comb begin
		if (norm_q) n_c = $signed({18'b0, e_s1}) - $signed({18'b0, a_s1});
		else        n_c = $signed({3'b0, e_s1, 15'b0}) - $signed({2'b0, am_s1});
		pos_c = (n_c > 0);
		if (pos_c) tau_c = (tau_act_q == '0) ? 16'd1 : tau_act_q;
		else       tau_c = (tau_dea_q == '0) ? 16'd1 : tau_dea_q;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s2  <= pos_c;
			absn_s2 <= pos_c ? n_c[32:0] : 33'(-n_c);
			tk_s2   <= tau_c * k_s1;
			tm_s2   <= tau_c * m_s1;
			k_s2    <= k_s1;
			m_s2    <= m_s1;
			over_s2 <= over_s1;
		end
	end

	// stage 3: scaled dividend and divisor
	logic [50:0]      nk_c;
	logic [49:0]      tkm_c;
	logic [NUM_W-1:0] x_c;
	logic             v_s3;
	logic [YW-1:0]    y_s3;
	logic [DEN_W-1:0] d_s3;
	mar_meta_t        meta_s3;

	always_comb begin
		nk_c  = absn_s2 * k_s2;
		tkm_c = tk_s2 * m_s2;
		x_c   = pos_s2 ? {{(NUM_W-33){1'b0}}, absn_s2} : nk_c[NUM_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_s3 <= pos_s2 ? ({{(YW-NUM_W){1'b0}}, x_c} << SH_POS)
			               : ({{(YW-NUM_W){1'b0}}, x_c} << SH_NEG);
			d_s3 <= pos_s2 ? tkm_c : {3'b0, tm_s2, 15'b0};
			meta_s3.neg  <= !pos_s2;
			meta_s3.over <= over_s2;
		end
	end

	// valid bits of the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_ch.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// quotient pipeline
	logic             dv_valid, dv_ovf;
	logic [QUO_W-1:0] dv_q;
	mar_meta_t        dv_meta;

	mar_div #(.YW(YW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s3),
		.y        (y_s3),
		.d        (d_s3),
		.meta_in  (meta_s3),
		.out_valid(dv_valid),
		.q        (dv_q),
		.ovf      (dv_ovf),
		.meta_out (dv_meta)
	);

	// output stage: round half up, saturate, apply sign
	logic [QUO_W:0]    qp1;
	logic [QUO_W-1:0]  mag;
	logic              sat_c;
	logic [RATE_W-1:0] rate_c;
	logic [RATE_W-1:0] rate_s5;
	logic              sat_s5, over_s5;

	always_comb begin
		qp1 = {1'b0, dv_q} + {{QUO_W{1'b0}}, 1'b1};
		mag = qp1[QUO_W:1];
		if (dv_meta.neg) begin
			sat_c  = dv_ovf || (mag > {2'b0, 32'h8000_0000});
			rate_c = sat_c ? 32'h8000_0000 : (32'd0 - mag[RATE_W-1:0]);
		end else begin
			sat_c  = dv_ovf || (mag > {2'b0, 32'h7FFF_FFFF});
			rate_c = sat_c ? 32'h7FFF_FFFF : mag[RATE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_s5 <= 1'b0;
		end else if (en) begin
			out_v_s5 <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rate_s5 <= rate_c;
			sat_s5  <= sat_c;
			over_s5 <= dv_meta.over;
		end
	end

	assign out_ch.valid               = out_v_s5;
	assign out_ch.activation_rate     = rate_s5;
	assign out_ch.saturated           = sat_s5;
	assign out_ch.excitation_over_max = over_s5;

	// checks
	`MAR_ASSERT_IMPLIES(a_sat_rail, out_v_s5 && sat_s5,
		rate_s5 == 32'h7FFF_FFFF || rate_s5 == 32'h8000_0000)
	`MAR_ASSERT_IMPLIES(a_norm_no_over, out_v_s5 && norm_q, !over_s5)
	`MAR_ASSERT_NEVER(a_zero_not_sat, out_v_s5 && sat_s5 && rate_s5 == '0)

endmodule

// ===== design/mar_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on mar_pkg.
module mar_div import mar_pkg::*; #(
	parameter int YW = 67
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [YW-1:0]    y,
	input  logic [DEN_W-1:0] d,
	input  mar_meta_t        meta_in,
	output logic             out_valid,
	output logic [QUO_W-1:0] q,
	output logic             ovf,
	output mar_meta_t        meta_out
);

	localparam int HW = YW - QUO_W;

	logic             v_s    [QUO_W+1];
	logic [DEN_W-1:0] rem_s  [QUO_W+1];
	logic [QUO_W-1:0] low_s  [QUO_W+1];
	logic [QUO_W-1:0] q_s    [QUO_W+1];
	logic [DEN_W-1:0] d_s    [QUO_W+1];
	logic             ovf_s  [QUO_W+1];
	mar_meta_t        meta_s [QUO_W+1];

	logic [DEN_W-1:0] hi;
	assign hi = {{(DEN_W-HW){1'b0}}, y[YW-1:QUO_W]};

	// entry stage: quotient would not fit if the top part already reaches d
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= hi;
			low_s[0]  <= y[QUO_W-1:0];
			q_s[0]    <= '0;
			d_s[0]    <= d;
			ovf_s[0]  <= (hi >= d);
			meta_s[0] <= meta_in;
		end
	end

	for (genvar i = 1; i <= QUO_W; i++) begin : g_step
		logic [DEN_W:0] t;
		logic           ge;
		logic [DEN_W:0] diff;

		always_comb begin
			t    = {rem_s[i-1], low_s[i-1][QUO_W-1]};
			ge   = (t >= {1'b0, d_s[i-1]});
			diff = t - {1'b0, d_s[i-1]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= v_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
				low_s[i]  <= {low_s[i-1][QUO_W-2:0], 1'b0};
				q_s[i]    <= {q_s[i-1][QUO_W-2:0], ge};
				d_s[i]    <= d_s[i-1];
				ovf_s[i]  <= ovf_s[i-1];
				meta_s[i] <= meta_s[i-1];
			end
		end
	end

	assign out_valid = v_s[QUO_W];
	assign q         = q_s[QUO_W];
	assign ovf       = ovf_s[QUO_W];
	assign meta_out  = meta_s[QUO_W];

endmodule
